// File: sv/rrb_pkg.sv
package rrb_pkg;

    localparam int RING_BYTES  = 4096;
    localparam int RING_AW     = $clog2(RING_BYTES);
    localparam int MAX_PAYLOAD = 1024;
    localparam int LEN_W       = 11;
    localparam int POS_W       = 12;
    localparam int DATA_W      = 8;

    typedef logic [RING_AW-1:0] t_addr;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_HEADER = 2'd1,
        FUNC_BYTE   = 2'd2,
        FUNC_DRAIN  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_BYTE     = 2'd1,
        KIND_EMPTY    = 2'd2,
        KIND_CONFLICT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CLS_IN_ORDER  = 2'd0,
        CLS_BUFFERED  = 2'd1,
        CLS_DELIVERED = 2'd2,
        CLS_NEW_OOO   = 2'd3
    } t_class;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // requests from the sequencer to the ring memories
    typedef struct packed {
        logic              rd_en;
        t_addr             rd_addr;
        logic              vld_we;
        t_addr             vld_addr;
        logic              vld_bit;
        logic              byte_we;
        t_addr             byte_addr;
        logic [DATA_W-1:0] byte_data;
    } t_ring_req;

endpackage

// File: sv/rrb_ring.sv
module rrb_ring (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rrb_pkg::t_ring_req        i_req,
    output logic                      o_rd_valid,
    output logic [rrb_pkg::DATA_W-1:0] o_rd_byte,
    output logic                      o_busy
);

    logic                      r_valid_mem [rrb_pkg::RING_BYTES];
    logic [rrb_pkg::DATA_W-1:0] r_byte_mem [rrb_pkg::RING_BYTES];

    logic                      r_rd_valid;
    logic [rrb_pkg::DATA_W-1:0] r_rd_byte;
    logic                      r_busy;
    rrb_pkg::t_addr            r_clr_addr;

    logic                      w_vld_we;
    rrb_pkg::t_addr            w_vld_addr;
    logic                      w_vld_bit;

    // the clearing sweep owns the valid write port until it finishes
    always_comb begin
        if (r_busy) begin
            w_vld_we   = 1'b1;
            w_vld_addr = r_clr_addr;
            w_vld_bit  = 1'b0;
        end else begin
            w_vld_we   = i_req.vld_we;
            w_vld_addr = i_req.vld_addr;
            w_vld_bit  = i_req.vld_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {rrb_pkg::RING_AW{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vld_we) begin
            r_valid_mem[w_vld_addr] <= w_vld_bit;
        end
        if (i_req.rd_en) begin
            r_rd_valid <= r_valid_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.byte_we) begin
            r_byte_mem[i_req.byte_addr] <= i_req.byte_data;
        end
        if (i_req.rd_en) begin
            r_rd_byte <= r_byte_mem[i_req.rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_byte  = r_rd_byte;
    assign o_busy     = r_busy;

endmodule

// File: sv/receive_reorder_buffer_ack_top.sv
// channel  | valid       | stall        | payload
// ---------+-------------+--------------+--------------------------------------------------
// in       | i_in_valid  | o_in_stall   | i_func i_position i_payload_len i_data_in
// out      | o_out_valid | i_out_stall  | o_result_kind o_ack_number o_packet_class o_data_out
//
// Each word is handled in S_IDLE, which reads its ring slot, then in S_EXEC, which classifies,
// writes back and updates the pointers; the registered read of the slot memories makes the split.
// After reset a sweep clears the slot valid bits, one slot a cycle, across all 4096 slots;
// no word is accepted until it ends.
// A stalled output holds the result register; a word that has a result then waits
// in S_EXEC until the register frees.
module receive_reorder_buffer_ack_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_func,
    input  logic [rrb_pkg::POS_W-1:0]  i_position,
    input  logic [rrb_pkg::LEN_W-1:0]  i_payload_len,
    input  logic [rrb_pkg::DATA_W-1:0] i_data_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_result_kind,
    output logic [rrb_pkg::POS_W-1:0]  o_ack_number,
    output logic [1:0]                 o_packet_class,
    output logic [rrb_pkg::DATA_W-1:0] o_data_out
);

    localparam logic [rrb_pkg::RING_AW:0] HALF_RING =
        (rrb_pkg::RING_AW+1)'(rrb_pkg::RING_BYTES / 2);
    localparam logic [rrb_pkg::LEN_W-1:0] MAX_LEN =
        rrb_pkg::LEN_W'(rrb_pkg::MAX_PAYLOAD);

    rrb_pkg::t_state            r_state, n_state;

    rrb_pkg::t_addr             r_deliver_ptr, n_deliver_ptr;
    rrb_pkg::t_addr             r_write_ptr, n_write_ptr;
    logic [rrb_pkg::LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic                       r_store_en, n_store_en;

    rrb_pkg::t_func             r_func;
    rrb_pkg::t_addr             r_pos;
    logic [rrb_pkg::LEN_W-1:0]  r_len;
    logic [rrb_pkg::DATA_W-1:0] r_data;

    logic                       r_out_valid;
    logic [1:0]                 r_out_kind;
    logic [rrb_pkg::POS_W-1:0]  r_out_ack;
    logic [1:0]                 r_out_class;
    logic [rrb_pkg::DATA_W-1:0] r_out_data;

    rrb_pkg::t_ring_req         w_req;
    logic                       w_rd_valid;
    logic [rrb_pkg::DATA_W-1:0] w_rd_byte;
    logic                       w_busy;

    logic                       w_accept;
    logic                       w_has_res;
    logic                       w_go;
    rrb_pkg::t_kind             w_kind;
    rrb_pkg::t_addr             w_ack;
    rrb_pkg::t_class            w_class;
    logic [rrb_pkg::DATA_W-1:0] w_data;
    logic [rrb_pkg::LEN_W-1:0]  w_len_sat;
    rrb_pkg::t_addr             w_dist;

    rrb_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rd_valid (w_rd_valid),
        .o_rd_byte  (w_rd_byte),
        .o_busy     (w_busy)
    );

    assign o_in_stall = w_busy || (r_state != rrb_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_len_sat  = (r_len > MAX_LEN) ? MAX_LEN : r_len;
    assign w_dist     = r_deliver_ptr - r_pos;

    always_comb begin
        n_state       = r_state;
        n_deliver_ptr = r_deliver_ptr;
        n_write_ptr   = r_write_ptr;
        n_bytes_left  = r_bytes_left;
        n_store_en    = r_store_en;
        w_has_res     = 1'b0;
        w_kind        = rrb_pkg::KIND_ACK;
        w_ack         = '0;
        w_class       = rrb_pkg::CLS_IN_ORDER;
        w_data        = '0;
        w_go          = 1'b0;

        w_req           = '0;
        w_req.byte_data = r_data;

        case (r_state)
            rrb_pkg::S_IDLE: begin
                if (w_accept) begin
                    // read the slot this word will touch
                    w_req.rd_en = 1'b1;
                    case (rrb_pkg::t_func'(i_func))
                        rrb_pkg::FUNC_HEADER: w_req.rd_addr = i_position[rrb_pkg::RING_AW-1:0];
                        rrb_pkg::FUNC_BYTE:   w_req.rd_addr = r_write_ptr;
                        default:              w_req.rd_addr = r_deliver_ptr;
                    endcase
                    n_state = rrb_pkg::S_EXEC;
                end
            end
            rrb_pkg::S_EXEC: begin
                case (r_func)
                    rrb_pkg::FUNC_START: begin
                        n_deliver_ptr = r_pos;
                    end
                    rrb_pkg::FUNC_HEADER: begin
                        w_has_res = 1'b1;
                        w_ack     = r_deliver_ptr;
                        if (r_pos == r_deliver_ptr) begin
                            w_class = rrb_pkg::CLS_IN_ORDER;
                            w_ack   = r_deliver_ptr + rrb_pkg::RING_AW'(w_len_sat);
                        end else if (w_rd_valid) begin
                            w_class = rrb_pkg::CLS_BUFFERED;
                        end else if ({1'b0, w_dist} <= HALF_RING) begin
                            w_class = rrb_pkg::CLS_DELIVERED;
                        end else begin
                            w_class = rrb_pkg::CLS_NEW_OOO;
                        end
                        n_store_en   = (w_class == rrb_pkg::CLS_IN_ORDER) ||
                                       (w_class == rrb_pkg::CLS_NEW_OOO);
                        n_write_ptr  = r_pos;
                        n_bytes_left = w_len_sat;
                    end
                    rrb_pkg::FUNC_BYTE: begin
                        if (r_bytes_left != '0) begin
                            n_bytes_left = r_bytes_left - 1'b1;
                            if (r_store_en) begin
                                if (w_rd_valid) begin
                                    w_has_res = 1'b1;
                                    w_kind    = rrb_pkg::KIND_CONFLICT;
                                end else begin
                                    w_req.vld_we    = 1'b1;
                                    w_req.vld_addr  = r_write_ptr;
                                    w_req.vld_bit   = 1'b1;
                                    w_req.byte_we   = 1'b1;
                                    w_req.byte_addr = r_write_ptr;
                                end
                                n_write_ptr = r_write_ptr + 1'b1;
                            end
                        end
                    end
                    default: begin
                        w_has_res = 1'b1;
                        if (w_rd_valid) begin
                            w_kind         = rrb_pkg::KIND_BYTE;
                            w_data         = w_rd_byte;
                            w_req.vld_we   = 1'b1;
                            w_req.vld_addr = r_deliver_ptr;
                            w_req.vld_bit  = 1'b0;
                            n_deliver_ptr  = r_deliver_ptr + 1'b1;
                        end else begin
                            w_kind = rrb_pkg::KIND_EMPTY;
                        end
                    end
                endcase

                w_go = !w_has_res || !r_out_valid || !i_out_stall;
                if (!w_go) begin
                    // hold: result register still full
                    n_deliver_ptr = r_deliver_ptr;
                    n_write_ptr   = r_write_ptr;
                    n_bytes_left  = r_bytes_left;
                    n_store_en    = r_store_en;
                    w_req.vld_we  = 1'b0;
                    w_req.byte_we = 1'b0;
                end else begin
                    n_state = rrb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rrb_pkg::S_IDLE;
            r_deliver_ptr <= '0;
            r_write_ptr   <= '0;
            r_bytes_left  <= '0;
            r_store_en    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_deliver_ptr <= n_deliver_ptr;
            r_write_ptr   <= n_write_ptr;
            r_bytes_left  <= n_bytes_left;
            r_store_en    <= n_store_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= rrb_pkg::t_func'(i_func);
            r_pos  <= i_position[rrb_pkg::RING_AW-1:0];
            r_len  <= i_payload_len;
            r_data <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has_res) begin
            r_out_kind  <= w_kind;
            r_out_ack   <= rrb_pkg::POS_W'(w_ack);
            r_out_class <= w_class;
            r_out_data  <= w_data;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_ack_number   = r_out_ack;
    assign o_packet_class = r_out_class;
    assign o_data_out     = r_out_data;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rrb_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 26;

    typedef struct {
        logic              sync;
        t_func             func;
        t_addr             pos;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_pend_word;

    typedef struct {
        t_kind             kind;
        t_addr             ack;
        t_class            cls;
        logic [DATA_W-1:0] data;
    } t_ack_word;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_func             in_func  = FUNC_START;
    t_addr             in_pos   = '0;
    logic [LEN_W-1:0]  in_len   = '0;
    logic [DATA_W-1:0] in_data  = '0;
    logic              out_stall = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_result_kind;
    logic [POS_W-1:0]  o_ack_number;
    logic [1:0]        o_packet_class;
    logic [DATA_W-1:0] o_data_out;

    receive_reorder_buffer_ack_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (in_func),
        .i_position     (in_pos),
        .i_payload_len  (in_len),
        .i_data_in      (in_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_result_kind  (o_result_kind),
        .o_ack_number   (o_ack_number),
        .o_packet_class (o_packet_class),
        .o_data_out     (o_data_out)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_pend_word pend_q[$];
    t_ack_word  results_due[$];
    int         n_words   = 0;
    int         words_in  = 0;
    int         errors    = 0;
    int         cycles    = 0;
    int         kind_cnt[4];
    int         cls_cnt[4];
    logic       drain_wait = 1'b0;
    logic       calm;

    // no idling on either side through this window of the run
    assign calm = (words_in >= 1000) && (words_in < 1300);

    // shadow of the reassembly ring
    bit                slot_full [RING_BYTES];
    logic [DATA_W-1:0] ring_byte [RING_BYTES];
    t_addr             next_out  = '0;
    t_addr             fill_ptr  = '0;
    logic [LEN_W-1:0]  fill_left = '0;
    logic              fill_keep = 1'b0;

    function automatic void reassemble_word(input t_func f, input t_addr pos,
                                            input logic [LEN_W-1:0] len,
                                            input logic [DATA_W-1:0] din);
        t_ack_word        r;
        t_addr            behind;
        logic [LEN_W-1:0] n;
        r = '{KIND_ACK, '0, CLS_IN_ORDER, '0};
        case (f)
            FUNC_START: next_out = pos;
            FUNC_HEADER: begin
                n      = (len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len;
                behind = next_out - pos;
                r.ack  = next_out;
                if (pos == next_out) begin
                    r.cls = CLS_IN_ORDER;
                    r.ack = next_out + t_addr'(n);
                end else if (slot_full[pos]) begin
                    r.cls = CLS_BUFFERED;
                end else if (behind != 0 && behind <= RING_BYTES / 2) begin
                    r.cls = CLS_DELIVERED;
                end else begin
                    r.cls = CLS_NEW_OOO;
                end
                fill_keep = (r.cls == CLS_IN_ORDER) || (r.cls == CLS_NEW_OOO);
                fill_ptr  = pos;
                fill_left = n;
                results_due.push_back(r);
            end
            FUNC_BYTE: begin
                if (fill_left != 0) begin
                    fill_left = fill_left - 1'b1;
                    if (fill_keep) begin
                        if (slot_full[fill_ptr]) begin
                            r.kind = KIND_CONFLICT;
                            results_due.push_back(r);
                        end else begin
                            ring_byte[fill_ptr] = din;
                            slot_full[fill_ptr] = 1'b1;
                        end
                        fill_ptr = fill_ptr + 1'b1;
                    end
                end
            end
            FUNC_DRAIN: begin
                if (slot_full[next_out]) begin
                    r.kind = KIND_BYTE;
                    r.data = ring_byte[next_out];
                    slot_full[next_out] = 1'b0;
                    next_out = next_out + 1'b1;
                end else begin
                    r.kind = KIND_EMPTY;
                end
                results_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                        input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void queue_word(input t_func f, input t_addr p,
                                       input logic [LEN_W-1:0] l, input logic [DATA_W-1:0] d);
        pend_q.push_back('{1'b0, f, p, l, d});
        n_words++;
    endfunction

    function automatic void send_start(input t_addr p);
        queue_word(FUNC_START, p, LEN_W'($urandom_range(2047)), DATA_W'($urandom_range(255)));
    endfunction

    function automatic void send_header(input t_addr p, input logic [LEN_W-1:0] l);
        queue_word(FUNC_HEADER, p, l, DATA_W'($urandom_range(255)));
    endfunction

    function automatic void send_byte(input logic [DATA_W-1:0] d);
        queue_word(FUNC_BYTE, t_addr'($urandom_range(4095)), LEN_W'($urandom_range(2047)), d);
    endfunction

    function automatic void send_drains(input int unsigned cnt);
        repeat (cnt)
            queue_word(FUNC_DRAIN, t_addr'($urandom_range(4095)),
                       LEN_W'($urandom_range(2047)), DATA_W'($urandom_range(255)));
    endfunction

    // sender holds here until every expected result has come back
    function automatic void hold_sender();
        pend_q.push_back('{1'b1, FUNC_START, '0, '0, '0});
    endfunction

    function automatic int unsigned pkt_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 90)
            return $urandom_range(1, 12);
        return $urandom_range(13, 200);
    endfunction

    // driver: offer the next word, hold it while stalled
    always @(posedge i_clk) begin : drive
        t_pend_word w;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                reassemble_word(in_func, in_pos, in_len, in_data);
                words_in <= words_in + 1;
            end
            if (!(in_valid && o_in_stall)) begin
                if (drain_wait) begin
                    if (results_due.size() == 0)
                        drain_wait = 1'b0;
                    in_valid <= 1'b0;
                end else if (pend_q.size() != 0 &&
                             (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    w = pend_q.pop_front();
                    if (w.sync) begin
                        drain_wait = 1'b1;
                        in_valid <= 1'b0;
                    end else begin
                        in_valid <= 1'b1;
                        in_func  <= w.func;
                        in_pos   <= w.pos;
                        in_len   <= w.len;
                        in_data  <= w.data;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word, stall at random
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin : watch
        t_ack_word exp;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !out_stall) begin
                kind_cnt[o_result_kind]++;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d",
                             $time, o_result_kind);
                    errors++;
                end else begin
                    exp = results_due.pop_front();
                    if (exp.kind == KIND_ACK)
                        cls_cnt[exp.cls]++;
                    check_field("result_kind", POS_W'(exp.kind), POS_W'(o_result_kind));
                    check_field("ack_number", exp.ack, o_ack_number);
                    check_field("packet_class", POS_W'(exp.cls), POS_W'(o_packet_class));
                    check_field("data_out", POS_W'(exp.data), POS_W'(o_data_out));
                end
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && words_in >= 400) begin
                // long hold-off: let the block fill up and back-pressure the sender
                hold_done <= 1'b1;
                hold_left <= 300;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        t_addr       seq;
        int unsigned lag, len, back, gap, k, d;
        logic        paused_mid;

        // directed: empty drain, wrap, stray byte, every class, conflict,
        // oversized length, header during payload
        send_drains(1);
        send_start(12'd4094);
        send_header(12'd4094, 11'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_header(12'd4095, 11'd0);
        send_header(12'd4000, 11'd0);
        send_header(12'd9, 11'd1);
        send_byte(8'h3C);
        send_header(12'd8, 11'd2);
        send_byte(8'hC3);
        send_byte(8'h77);
        send_header(12'd4094, 11'd2047);
        send_byte(8'h11);
        send_header(12'd4095, 11'd5);
        send_drains(4);
        send_start(12'd0);
        hold_sender();

        seq = '0;
        lag = 0;
        paused_mid = 1'b0;
        while (n_words < 1950) begin
            k = $urandom_range(99);
            if (k < 50) begin
                len = pkt_len();
                send_header(seq, LEN_W'(len));
                repeat (len) send_byte(DATA_W'($urandom_range(255)));
                seq = t_addr'(seq + len);
                lag += len;
            end else if (k < 62) begin
                // later segment first, then fill the gap, sometimes overlapping
                gap = $urandom_range(1, 8);
                len = $urandom_range(1, 8);
                send_header(t_addr'(seq + gap), LEN_W'(len));
                repeat (len) send_byte(DATA_W'($urandom_range(255)));
                back = gap + ($urandom_range(3) == 0);
                send_header(seq, LEN_W'(back));
                repeat (back) send_byte(DATA_W'($urandom_range(255)));
                seq = t_addr'(seq + gap + len);
                lag += gap + len;
            end else if (k < 72) begin
                back = $urandom_range(1, 48);
                len  = $urandom_range(0, 6);
                send_header(t_addr'(seq - back), LEN_W'(len));
                repeat (len) send_byte(DATA_W'($urandom_range(255)));
            end else if (k < 76) begin
                if ($urandom_range(2) == 0) begin
                    seq = t_addr'($urandom_range(4095));
                    lag = 0;
                end
                send_start(t_addr'(seq - lag));
            end else if (k < 79) begin
                // oversized or maximum length, cut short by the next header
                send_header(seq, LEN_W'($urandom_range(1) ? 1024 : $urandom_range(1025, 2047)));
                gap = $urandom_range(1, 4);
                repeat (gap) send_byte(DATA_W'($urandom_range(255)));
                seq = t_addr'(seq + gap);
                lag += gap;
            end else begin
                case ($urandom_range(3))
                    0: send_byte(DATA_W'($urandom_range(255)));
                    1: begin
                        send_header(t_addr'($urandom_range(4095)),
                                    LEN_W'($urandom_range(2047)));
                        repeat ($urandom_range(3)) send_byte(DATA_W'($urandom_range(255)));
                    end
                    2: send_drains($urandom_range(1, 4));
                    default: begin
                        send_header(seq, 11'd4);
                        send_byte(DATA_W'($urandom_range(255)));
                        send_start(t_addr'(seq - lag));
                        repeat (3) send_byte(DATA_W'($urandom_range(255)));
                        seq = t_addr'(seq + 4);
                        lag += 4;
                    end
                endcase
            end
            d = $urandom_range(lag / 2, lag + 1);
            send_drains(d);
            lag = (d >= lag) ? 0 : lag - d;
            if (!paused_mid && n_words >= 1000) begin
                hold_sender();
                paused_mid = 1'b1;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || drain_wait || in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d words in; results: %0d acks, %0d bytes, %0d empty, %0d conflicts",
                 words_in, kind_cnt[KIND_ACK], kind_cnt[KIND_BYTE], kind_cnt[KIND_EMPTY],
                 kind_cnt[KIND_CONFLICT]);
        $display("ack classes: in order %0d, buffered dup %0d, delivered dup %0d, new ooo %0d",
                 cls_cnt[CLS_IN_ORDER], cls_cnt[CLS_BUFFERED], cls_cnt[CLS_DELIVERED],
                 cls_cnt[CLS_NEW_OOO]);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/rrb_pkg.sv
sv/rrb_ring.sv
sv/receive_reorder_buffer_ack_top.sv
sim/testbench.sv
